// ----- src/distinct_value_set_table_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the distinct value set table
// Shared forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef DISTINCT_VALUE_SET_TABLE_MACROS_SVH
`define DISTINCT_VALUE_SET_TABLE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define DVST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define DVST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/dvst_pkg.sv -----
// ----------------------------------------------------------------------------
// dvst_pkg
// Operation and status codes, and the command and status bundles that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package dvst_pkg;

  // Operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_MEMBER = 2'd2;
  localparam logic [1:0] OP_UPDATE = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_DUPLICATE = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // Field widths
  localparam int VAL_W = 32;
  localparam int CNT_W = 5;

  // Controller to datapath
  typedef struct packed {
    logic start;   // latch request, clear match flags, rewind scan
    logic scan;    // issue read of the next slot
    logic decide;  // resolve result, write store, update count, load output
    logic move;    // copy the old last entry into the freed slot
  } dvst_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cnt_zero;   // store empty
    logic scan_last;  // current scan slot is the last occupied one
    logic need_move;  // remove hit a present value
  } dvst_sts_t;

endpackage

// ----- src/distinct_value_set_table.sv -----
// ----------------------------------------------------------------------------
// distinct_value_set_table
// Fixed-capacity set of distinct signed 32-bit values with insert, remove,
// membership test and update; one result per request.
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  --------+-----------+---------------------------------------------------
//  in      | input     | in_valid, in_ready, in_opcode, in_value, in_new_value
//  out     | output    | out_valid, out_ready, out_status, out_found, out_count
//
//  A request passes the scan, drain and decide steps, and a remove that hits
//  a move step after them; the scan reads one slot a cycle through the store
//  RAM read port, and an empty store skips the scan and drain steps.
//  Reset clears state, match flags and count only; store entries are never used before written.
//  A result waiting on out_ready does not block acceptance of the next
//  request; only resolving the next one waits for the output slot.
// ----------------------------------------------------------------------------
`include "distinct_value_set_table_macros.svh"

module distinct_value_set_table import dvst_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_opcode,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic signed [VAL_W-1:0] in_new_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_status,
  output logic                    out_found,
  output logic [CNT_W-1:0]        out_count
);

  dvst_cmd_t cmd;
  dvst_sts_t sts;

  dvst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dvst_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_opcode    (in_opcode),
    .in_value     (in_value),
    .in_new_value (in_new_value),
    .cmd          (cmd),
    .sts          (sts),
    .out_status   (out_status),
    .out_found    (out_found),
    .out_count    (out_count)
  );

  // Checks
  `DVST_ASSERT_NOW(a_no_accept_on_decide, in_valid && in_ready, !cmd.decide, "accept during decide")
  `DVST_ASSERT_NEXT(a_decide_loads_out, cmd.decide, out_valid, "decide did not raise out_valid")
  `DVST_ASSERT_NOW(a_move_after_decide, cmd.move, $past(cmd.decide), "move without decide")
  `DVST_ASSERT_NOW(a_decide_slot_free, cmd.decide, !$past(out_valid) || !out_valid || out_ready, "decide overwrote pending result")

endmodule

// ----- src/dvst_ram.sv -----
// ----------------------------------------------------------------------------
// dvst_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module dvst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- src/dvst_ctrl.sv -----
// ----------------------------------------------------------------------------
// dvst_ctrl
// Request sequencer: accept, scan the occupied slots, resolve, and for a
// remove copy the last entry into the freed slot. Owns the output valid.
// ----------------------------------------------------------------------------
module dvst_ctrl import dvst_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  dvst_sts_t sts,
  output dvst_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_MOVE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = sts.cnt_zero ? S_DECIDE : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (!out_valid_r || out_ready) begin
          cmd.decide = 1'b1;
          state_nxt  = sts.need_move ? S_MOVE : S_IDLE;
        end
      end
      S_MOVE: begin
        cmd.move  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Load the output slot on decide, drop it when taken
  always_comb begin
    if (cmd.decide) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Hold state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- src/dvst_datapath.sv -----
// ----------------------------------------------------------------------------
// dvst_datapath
// Request registers, scan counter and comparators, element count, element
// store and the result register.
// ----------------------------------------------------------------------------
module dvst_datapath import dvst_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [1:0]              in_opcode,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic signed [VAL_W-1:0] in_new_value,
  input  dvst_cmd_t               cmd,
  output dvst_sts_t               sts,
  output logic [1:0]              out_status,
  output logic                    out_found,
  output logic [CNT_W-1:0]        out_count
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [1:0]              op_r;
  logic signed [VAL_W-1:0] v_r;
  logic signed [VAL_W-1:0] nv_r;
  logic [AW-1:0]           idx_r;
  logic                    cmp_vld_r;
  logic [AW-1:0]           cmp_idx_r;
  logic                    hit_v_r;
  logic                    hit_nv_r;
  logic [AW-1:0]           hit_slot_r;
  logic [CW-1:0]           count_r;
  logic [1:0]              status_r;
  logic                    found_r;
  logic [CNT_W-1:0]        ocount_r;

  logic [1:0]              status_nxt;
  logic [CW-1:0]           count_nxt;
  logic [CW-1:0]           last_cnt;
  logic                    full;
  logic                    ins_wr;
  logic                    upd_wr;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic [VAL_W-1:0]        wr_data;
  logic [AW-1:0]           rd_addr;
  logic [VAL_W-1:0]        rd_data;

  assign last_cnt = count_r - CW'(1);
  assign full     = (count_r == CW'(CAPACITY));

  // Resolve the request from the scan results
  always_comb begin
    status_nxt = ST_DONE;
    count_nxt  = count_r;
    ins_wr     = 1'b0;
    upd_wr     = 1'b0;
    case (op_r)
      OP_INSERT: begin
        if (hit_v_r) begin
          status_nxt = ST_DUPLICATE;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ins_wr    = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
      OP_REMOVE: begin
        if (!hit_v_r) begin
          status_nxt = ST_NOT_FOUND;
        end else begin
          count_nxt = last_cnt;
        end
      end
      OP_MEMBER: begin
        if (!hit_v_r) begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      OP_UPDATE: begin
        if (!hit_v_r) begin
          status_nxt = ST_NOT_FOUND;
        end else if (hit_nv_r) begin
          status_nxt = ST_DUPLICATE;
        end else begin
          upd_wr = 1'b1;
        end
      end
      default: begin
        status_nxt = ST_DONE;
      end
    endcase
  end

  // Store port selection: append, replace in place, or fill the hole
  assign wr_en   = (cmd.decide && (ins_wr || upd_wr)) || cmd.move;
  assign wr_addr = (cmd.decide && ins_wr) ? count_r[AW-1:0] : hit_slot_r;
  assign wr_data = cmd.move ? rd_data : (ins_wr ? v_r : nv_r);
  // A remove reads the old last entry while it resolves
  assign rd_addr = cmd.decide ? last_cnt[AW-1:0] : idx_r;

  dvst_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Control registers: scan pipeline, match flags, element count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r <= 1'b0;
      hit_v_r   <= 1'b0;
      hit_nv_r  <= 1'b0;
      count_r   <= '0;
    end else begin
      cmp_vld_r <= cmd.scan;
      if (cmd.start) begin
        hit_v_r  <= 1'b0;
        hit_nv_r <= 1'b0;
      end else if (cmp_vld_r) begin
        if (rd_data == v_r) begin
          hit_v_r <= 1'b1;
        end
        if (rd_data == nv_r) begin
          hit_nv_r <= 1'b1;
        end
      end
      if (cmd.decide) begin
        count_r <= count_nxt;
      end
    end
  end

  // Payload registers: request, scan address, hit slot, result
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r  <= in_opcode;
      v_r   <= in_value;
      nv_r  <= in_new_value;
      idx_r <= '0;
    end else if (cmd.scan) begin
      idx_r <= idx_r + AW'(1);
    end
    cmp_idx_r <= idx_r;
    if (cmp_vld_r && (rd_data == v_r)) begin
      hit_slot_r <= cmp_idx_r;
    end
    if (cmd.decide) begin
      status_r <= status_nxt;
      found_r  <= hit_v_r;
      ocount_r <= CNT_W'(count_nxt);
    end
  end

  assign sts.cnt_zero  = (count_r == '0);
  assign sts.scan_last = (CW'(idx_r) == last_cnt);
  assign sts.need_move = (op_r == OP_REMOVE) && hit_v_r;

  assign out_status = status_r;
  assign out_found  = found_r;
  assign out_count  = ocount_r;

endmodule

// ----- sim/distinct_value_set_table_tb.sv -----
// ----------------------------------------------------------------------------
// distinct_value_set_table_tb
// Drives insert, remove, membership and update requests into the set table
// and checks each result against a cycle-free set model kept in the bench.
// Directed tests hit the empty store, the value extremes, every status and
// the full store; a long stall on the result side fills the block; random
// phases swing the store between nearly empty and full.
// ----------------------------------------------------------------------------
module distinct_value_set_table_tb;
  import dvst_pkg::*;

  localparam int CAPACITY   = 16;
  localparam int POOL_N     = 16;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_WAIT = 40;
  localparam int HOLD_LEN   = 300;

  typedef struct packed {
    logic [1:0]       status;
    logic             found;
    logic [CNT_W-1:0] count;
  } set_outcome_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [1:0]              in_opcode = OP_INSERT;
  logic signed [VAL_W-1:0] in_value = '0;
  logic signed [VAL_W-1:0] in_new_value = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [1:0]              out_status;
  logic                    out_found;
  logic [CNT_W-1:0]        out_count;

  // Set model state
  logic [VAL_W-1:0] set_slots [CAPACITY];
  int               set_size = 0;

  set_outcome_t     pending_outcomes [$];
  set_outcome_t     oldest_outcome;
  logic [VAL_W-1:0] value_pool [POOL_N];

  bit idle_en      = 1'b1;
  int hold_request = 0;
  int error_count  = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int full_rejects = 0;
  int drained      = 0;
  int idle_cycles  = 0;

  distinct_value_set_table #(.CAPACITY(CAPACITY)) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (in_opcode),
    .in_value     (in_value),
    .in_new_value (in_new_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_found    (out_found),
    .out_count    (out_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Return the slot holding v, or -1 when absent
  function automatic int slot_of(input logic [VAL_W-1:0] v);
    for (int i = 0; i < set_size; i++) begin
      if (set_slots[i] == v) return i;
    end
    return -1;
  endfunction

  // Apply one request to the set model and return its outcome
  function automatic set_outcome_t apply_set_op(input logic [1:0] op,
                                                input logic [VAL_W-1:0] v,
                                                input logic [VAL_W-1:0] nv);
    set_outcome_t r;
    int slot;
    slot     = slot_of(v);
    r.status = ST_DONE;
    r.found  = (slot >= 0);
    case (op)
      OP_INSERT: begin
        if (slot >= 0) begin
          r.status = ST_DUPLICATE;
        end else if (set_size >= CAPACITY) begin
          r.status = ST_FULL;
          full_rejects++;
        end else begin
          set_slots[set_size] = v;
          set_size++;
        end
      end
      OP_REMOVE: begin
        if (slot < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          // Move the last entry into the hole
          set_slots[slot] = set_slots[set_size-1];
          set_size--;
          if (set_size == 0) drained++;
        end
      end
      OP_MEMBER: begin
        if (slot < 0) r.status = ST_NOT_FOUND;
      end
      default: begin
        if (slot < 0) r.status = ST_NOT_FOUND;
        else if (slot_of(nv) >= 0) r.status = ST_DUPLICATE;
        else set_slots[slot] = nv;
      end
    endcase
    r.count = set_size[CNT_W-1:0];
    return r;
  endfunction

  // Offer one transaction and wait for its acceptance
  task automatic send_request(input logic [1:0] op, input logic [VAL_W-1:0] v,
                              input logic [VAL_W-1:0] nv);
    int gap;
    gap = idle_en ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_value     <= v;
    in_new_value <= nv;
    do @(posedge clk); while (!in_ready);
    pending_outcomes.push_back(apply_set_op(op, v, nv));
    requests_sent++;
  endtask

  // Draw a value: a held one, a pool one or a fully random one
  function automatic logic [VAL_W-1:0] pick_value(input int held_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < held_pct && set_size > 0) return set_slots[$urandom_range(0, set_size-1)];
    if (roll < 90) return value_pool[$urandom_range(0, POOL_N-1)];
    return $urandom();
  endfunction

  task automatic send_random(input int insert_pct, input int remove_pct);
    int roll;
    logic [1:0] op;
    roll = $urandom_range(0, 99);
    if (roll < insert_pct) op = OP_INSERT;
    else if (roll < insert_pct + remove_pct) op = OP_REMOVE;
    else if (roll < insert_pct + remove_pct + (100 - insert_pct - remove_pct) / 2) op = OP_MEMBER;
    else op = OP_UPDATE;
    send_request(op, pick_value(50), pick_value(30));
  endtask

  // Fill the value pool with the extremes and random values
  task automatic init_value_pool();
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;
    value_pool[4] = 32'h0000_0001;
    for (int i = 5; i < POOL_N; i++) value_pool[i] = $urandom();
  endtask

  // Remove, membership and update on an empty store all miss
  task automatic test_empty_store();
    send_request(OP_REMOVE, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_MEMBER, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_UPDATE, 32'h0000_0000, 32'h0000_0001);
  endtask

  // Value extremes and each status of every operation but a full insert
  task automatic test_extremes();
    send_request(OP_INSERT, 32'h8000_0000, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'h7FFF_FFFF, 32'h0000_0000);
    send_request(OP_INSERT, 32'h0000_0000, 32'h8000_0000);
    send_request(OP_INSERT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_request(OP_INSERT, 32'h7FFF_FFFF, 32'h0000_0000);
    send_request(OP_MEMBER, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_MEMBER, 32'h0000_0001, 32'h0000_0000);
    send_request(OP_REMOVE, 32'h0001_2345, 32'h0000_0000);
    send_request(OP_REMOVE, 32'h8000_0000, 32'h0000_0000);
    send_request(OP_UPDATE, 32'h0000_0005, 32'h0000_0006);
    send_request(OP_UPDATE, 32'h0000_0000, 32'h7FFF_FFFF);
    send_request(OP_UPDATE, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_UPDATE, 32'h0000_0000, 32'h5555_5555);
    send_request(OP_MEMBER, 32'h0000_0000, 32'h0000_0000);
  endtask

  // Fill the store, then hit it with insert, update and remove while full
  task automatic test_full_store();
    while (set_size < CAPACITY) begin
      send_request(OP_INSERT, {4'(set_size), 28'h0C0_FFEE}, 32'h0000_0000);
    end
    send_request(OP_INSERT, 32'h1357_9BDF, 32'h0000_0000);
    send_request(OP_INSERT, set_slots[5], 32'h0000_0000);
    send_request(OP_UPDATE, set_slots[0], set_slots[CAPACITY-1]);
    send_request(OP_UPDATE, set_slots[3], 32'h2468_ACE0);
    send_request(OP_REMOVE, set_slots[CAPACITY-1], 32'h0000_0000);
    send_request(OP_REMOVE, set_slots[0], 32'h0000_0000);
    send_request(OP_INSERT, 32'h1357_9BDF, 32'h0000_0000);
  endtask

  // Stall the result side long enough that the block refuses requests
  task automatic test_backpressure();
    idle_en      = 1'b0;
    hold_request = HOLD_LEN;
    repeat (24) send_random(35, 35);
    idle_en      = 1'b1;
  endtask

  // Alternate insert-heavy and remove-heavy phases over a mixed value pool
  task automatic test_random();
    for (int phase = 0; phase < 4; phase++) begin
      idle_en = (phase != 1);
      repeat (250) begin
        if (phase % 2 == 0) send_random(55, 10);
        else send_random(10, 55);
      end
    end
    idle_en = 1'b1;
  endtask

  // Result side: random stalls, plus a long hold when one is asked for
  initial begin
    int stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        out_ready <= 1'b0;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end
      stall = idle_en ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compare each result transaction with the oldest outcome
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_outcomes.size() == 0) begin
        $display("%0t: result with nothing expected: status %0d found %0d count %0d",
                 $time, out_status, out_found, out_count);
        error_count++;
      end else begin
        oldest_outcome = pending_outcomes.pop_front();
        if (out_status !== oldest_outcome.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $time, oldest_outcome.status, out_status);
          error_count++;
        end
        if (out_found !== oldest_outcome.found) begin
          $display("%0t: found expected %0d actual %0d",
                   $time, oldest_outcome.found, out_found);
          error_count++;
        end
        if (out_count !== oldest_outcome.count) begin
          $display("%0t: count expected %0d actual %0d",
                   $time, oldest_outcome.count, out_count);
          error_count++;
        end
      end
    end
  end

  // Watchdog: stop when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    init_value_pool();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_store();
    test_extremes();
    test_full_store();
    test_backpressure();
    test_random();
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("%0d requests sent, %0d results checked", requests_sent, results_seen);
    $display("full store refused %0d inserts; store drained to empty %0d times",
             full_rejects, drained);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
